@@ rtl/core/usm_pkg.sv @@
package usm_pkg;

  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned INDEX_BITS_DEF = 16;

  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned IDX_W     = 16;

  // Mesh geometry widths: points per ring, rings, vertex and triangle counts.
  localparam int unsigned P_W   = 9;
  localparam int unsigned R_W   = 8;
  localparam int unsigned N_W   = 17;
  localparam int unsigned T_W   = 18;
  localparam int unsigned DIV_W = 17;

  localparam int unsigned FULL_TURN     = 360;
  localparam int unsigned HALF_TURN     = 180;
  localparam int unsigned THREE_QUARTER = 270;
  localparam int unsigned QUARTER       = 90;
  localparam int unsigned RAMP_TOP      = 235;
  localparam int unsigned RAMP_STEP     = 20;
  localparam int unsigned RAMP_LIMIT    = 13;
  localparam int unsigned STEP_RESET    = 10;

  localparam logic [63:0] DEG_Q30 = 64'd18740330;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X,
    CFG_CENTER_Y,
    CFG_CENTER_Z,
    CFG_RADIUS,
    CFG_STEP,
    CFG_RED,
    CFG_GREEN,
    CFG_BLUE
  } cfg_reg_e;

  typedef enum logic {
    OP_VERTEX   = 1'b0,
    OP_TRIANGLE = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    MUL_RXY,
    MUL_Z,
    MUL_X,
    MUL_Y
  } mul_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_CHECK,
    ST_DIV,
    ST_POST,
    ST_TRI,
    ST_MUL_RXY,
    ST_MUL_Z,
    ST_MUL_X,
    ST_MUL_Y,
    ST_RAMP,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic     load;
    logic     setup;
    logic     check;
    logic     post;
    logic     tri_calc;
    logic     mul_issue;
    mul_sel_e mul_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic is_tri;
    logic div_busy;
    logic ramp_busy;
  } stat_t;

  typedef struct packed {
    logic       neg;
    logic [6:0] k;
  } trig_ref_t;

  typedef logic [30:0] sin_tab_t [0:90];

  // Sine of whole degrees 0..90 in Q1.30, odd Taylor series up to x^15/15!,
  // each term truncated. Evaluated once at elaboration.
  function automatic sin_tab_t build_sin_tab();
    sin_tab_t    tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] r;
    logic [63:0] t;
    for (int k = 0; k <= 90; k++) begin
      x    = 64'(k) * DEG_Q30;
      x2   = (x * x) >> 30;
      term = x;
      pos  = x;
      neg  = 64'd0;
      for (int n = 1; n <= 7; n++) begin
        t = (term * x2) >> 30;
        unique case (n)
          1:       term = t / 64'd6;
          2:       term = t / 64'd20;
          3:       term = t / 64'd42;
          4:       term = t / 64'd72;
          5:       term = t / 64'd110;
          6:       term = t / 64'd156;
          default: term = t / 64'd210;
        endcase
        if ((n % 2) == 1) begin
          neg = neg + term;
        end else begin
          pos = pos + term;
        end
      end
      r = (pos > neg) ? pos - neg : 64'd0;
      if (r > ONE_Q30) begin
        r = ONE_Q30;
      end
      tab[k] = r[30:0];
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

  // Reduces an angle in 0..359 degrees to a first-quadrant index and a sign.
  function automatic trig_ref_t sin_ref(logic [8:0] a);
    trig_ref_t res;
    if (a <= 9'(QUARTER)) begin
      res.neg = 1'b0;
      res.k   = a[6:0];
    end else if (a <= 9'(HALF_TURN)) begin
      res.neg = 1'b0;
      res.k   = 7'(9'(HALF_TURN) - a);
    end else if (a <= 9'(THREE_QUARTER)) begin
      res.neg = 1'b1;
      res.k   = 7'(a - 9'(HALF_TURN));
    end else begin
      res.neg = 1'b1;
      res.k   = 7'(9'(FULL_TURN) - a);
    end
    return res;
  endfunction

  // Points per ring for a step that divides 180; zero marks a bad step.
  function automatic logic [P_W-1:0] step_points(logic [6:0] d);
    logic [P_W-1:0] p;
    unique case (d)
      7'd1:    p = 9'd360;
      7'd2:    p = 9'd180;
      7'd3:    p = 9'd120;
      7'd4:    p = 9'd90;
      7'd5:    p = 9'd72;
      7'd6:    p = 9'd60;
      7'd9:    p = 9'd40;
      7'd10:   p = 9'd36;
      7'd12:   p = 9'd30;
      7'd15:   p = 9'd24;
      7'd18:   p = 9'd20;
      7'd20:   p = 9'd18;
      7'd30:   p = 9'd12;
      7'd36:   p = 9'd10;
      7'd45:   p = 9'd8;
      7'd60:   p = 9'd6;
      7'd90:   p = 9'd4;
      default: p = 9'd0;
    endcase
    return p;
  endfunction

endpackage

@@ rtl/core/usm_if.sv @@
interface usm_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] item_index;

  modport source (output valid, output opcode, output item_index, input ready);
  modport sink (input valid, input opcode, input item_index, output ready);
endinterface

interface usm_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic        [7:0]  red;
  logic        [7:0]  green;
  logic        [7:0]  blue;
  logic        [15:0] corner_a;
  logic        [15:0] corner_b;
  logic        [15:0] corner_c;
  logic               status;

  modport source (
    output valid, output pos_x, output pos_y, output pos_z,
    output red, output green, output blue,
    output corner_a, output corner_b, output corner_c, output status,
    input ready
  );
  modport sink (
    input valid, input pos_x, input pos_y, input pos_z,
    input red, input green, input blue,
    input corner_a, input corner_b, input corner_c, input status,
    output ready
  );
endinterface

@@ rtl/core/uv_sphere_mesh_generator_top.sv @@
// Latitude-longitude sphere mesh generator. Each request item names a vertex
// (opcode 0) or a triangle (opcode 1) by index and yields exactly one result
// item. A vertex comes back as Q16.16 coordinates around the configured center
// plus an RGB color from the ramp; a triangle comes back as three vertex
// indices from the top cap fan, the band quads or the bottom cap fan. An index
// beyond the mesh, or an angle step that does not divide 180, returns status 1
// with every other field zero. The block handles one item at a time: a request
// is taken only while the controller is idle. Each item runs through the
// bit-serial divider that splits the index into ring and point (band and
// point for a triangle); a vertex then makes four passes through the one
// shared 31x31 multiplier (ring radius, z, x, y) while the color ramp runs one
// step per cycle for up to 13 steps. A finished item waits in the output
// register until taken, and the next request is accepted meanwhile.
module uv_sphere_mesh_generator_top #(
  parameter int unsigned FRAC_BITS  = usm_pkg::FRAC_BITS_DEF,
  parameter int unsigned INDEX_BITS = usm_pkg::INDEX_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [usm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [usm_pkg::CFG_W-1:0]     cfg_data_i,
  usm_req_if.sink                       req,
  usm_rsp_if.source                     rsp
);

  usm_pkg::cmd_t  cmd;
  usm_pkg::stat_t stat;

  // The controller only sequences; all arithmetic lives in the datapath.
  usm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .rsp_valid_o (rsp.valid),
    .rsp_ready_i (rsp.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  usm_dpath #(
    .FRAC_BITS  (FRAC_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .opcode_i     (req.opcode),
    .item_index_i (req.item_index),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .pos_x_o      (rsp.pos_x),
    .pos_y_o      (rsp.pos_y),
    .pos_z_o      (rsp.pos_z),
    .red_o        (rsp.red),
    .green_o      (rsp.green),
    .blue_o       (rsp.blue),
    .corner_a_o   (rsp.corner_a),
    .corner_b_o   (rsp.corner_b),
    .corner_c_o   (rsp.corner_c),
    .status_o     (rsp.status)
  );

endmodule

@@ rtl/core/usm_div.sv @@
module usm_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [usm_pkg::DIV_W-1:0]    num_i,
  input  logic [usm_pkg::P_W-1:0]      den_i,
  output logic                         busy_o,
  output logic [usm_pkg::DIV_W-1:0]    quot_o,
  output logic [usm_pkg::P_W-1:0]      rem_o
);

  localparam int unsigned CNT_W = $clog2(usm_pkg::DIV_W + 1);

  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic [usm_pkg::DIV_W-1:0] quo_q, quo_d;
  logic [usm_pkg::P_W-1:0]   rem_q, rem_d;
  logic [usm_pkg::P_W:0]     trial;
  logic                      fits;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    trial = {rem_q, quo_q[usm_pkg::DIV_W-1]};
    fits  = trial >= {1'b0, den_i};
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    if (start_i) begin
      cnt_d = CNT_W'(usm_pkg::DIV_W);
      quo_d = num_i;
      rem_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      quo_d = {quo_q[usm_pkg::DIV_W-2:0], fits};
      rem_d = fits ? usm_pkg::P_W'(trial - {1'b0, den_i}) : trial[usm_pkg::P_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign busy_o = cnt_q != '0;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

@@ rtl/core/usm_ctrl.sv @@
module usm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  input  usm_pkg::stat_t stat_i,
  output usm_pkg::cmd_t  cmd_o
);

  usm_pkg::state_e state_q, state_d;
  logic            out_full_q, out_full_d;

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.mul_sel   = usm_pkg::MUL_RXY;
    req_ready_o     = 1'b0;
    unique case (state_q)
      usm_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = usm_pkg::ST_SETUP;
        end
      end
      usm_pkg::ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = usm_pkg::ST_CHECK;
      end
      usm_pkg::ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = usm_pkg::ST_DIV;
      end
      usm_pkg::ST_DIV: begin
        if (stat_i.err) begin
          state_d = usm_pkg::ST_FINISH;
        end else if (!stat_i.div_busy) begin
          state_d = stat_i.is_tri ? usm_pkg::ST_TRI : usm_pkg::ST_POST;
        end
      end
      usm_pkg::ST_TRI: begin
        cmd_o.tri_calc = 1'b1;
        state_d        = usm_pkg::ST_FINISH;
      end
      usm_pkg::ST_POST: begin
        cmd_o.post = 1'b1;
        state_d    = usm_pkg::ST_MUL_RXY;
      end
      usm_pkg::ST_MUL_RXY: begin
        cmd_o.mul_issue = 1'b1;
        cmd_o.mul_sel   = usm_pkg::MUL_RXY;
        state_d         = usm_pkg::ST_MUL_Z;
      end
      usm_pkg::ST_MUL_Z: begin
        cmd_o.mul_issue = 1'b1;
        cmd_o.mul_sel   = usm_pkg::MUL_Z;
        state_d         = usm_pkg::ST_MUL_X;
      end
      usm_pkg::ST_MUL_X: begin
        cmd_o.mul_issue = 1'b1;
        cmd_o.mul_sel   = usm_pkg::MUL_X;
        state_d         = usm_pkg::ST_MUL_Y;
      end
      usm_pkg::ST_MUL_Y: begin
        cmd_o.mul_issue = 1'b1;
        cmd_o.mul_sel   = usm_pkg::MUL_Y;
        state_d         = usm_pkg::ST_RAMP;
      end
      usm_pkg::ST_RAMP: begin
        if (!stat_i.ramp_busy) begin
          state_d = usm_pkg::ST_FINISH;
        end
      end
      usm_pkg::ST_FINISH: begin
        if (!out_full_q || rsp_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = usm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = usm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_full_d = out_full_q;
    if (cmd_o.out_load) begin
      out_full_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= usm_pkg::ST_IDLE;
      out_full_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      out_full_q <= out_full_d;
    end
  end

  assign rsp_valid_o = out_full_q;

endmodule

@@ rtl/core/usm_dpath.sv @@
module usm_dpath #(
  parameter int unsigned FRAC_BITS  = usm_pkg::FRAC_BITS_DEF,
  parameter int unsigned INDEX_BITS = usm_pkg::INDEX_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [usm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [usm_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                            opcode_i,
  input  logic [usm_pkg::IDX_W-1:0]       item_index_i,
  input  usm_pkg::cmd_t                   cmd_i,
  output usm_pkg::stat_t                  stat_o,
  output logic signed [31:0]              pos_x_o,
  output logic signed [31:0]              pos_y_o,
  output logic signed [31:0]              pos_z_o,
  output logic [7:0]                      red_o,
  output logic [7:0]                      green_o,
  output logic [7:0]                      blue_o,
  output logic [15:0]                     corner_a_o,
  output logic [15:0]                     corner_b_o,
  output logic [15:0]                     corner_c_o,
  output logic                            status_o
);

  localparam logic [15:0] IDX_MASK =
    (INDEX_BITS >= 16) ? 16'hFFFF : 16'((64'd1 << INDEX_BITS) - 64'd1);
  localparam logic [30:0] RADIUS_RST = 31'(64'd1 << FRAC_BITS);
  localparam int unsigned P_W = usm_pkg::P_W;
  localparam int unsigned T_W = usm_pkg::T_W;

  function automatic logic [7:0] ramp_step(logic [7:0] c);
    logic [7:0] v;
    v = c;
    if (v < 8'(usm_pkg::RAMP_TOP)) begin
      v = v + 8'(usm_pkg::RAMP_STEP);
    end
    if (v > 8'(usm_pkg::RAMP_TOP)) begin
      v = v - 8'(usm_pkg::RAMP_STEP);
    end
    return v;
  endfunction

  function automatic logic signed [31:0] sat_add(logic signed [31:0] c,
                                                 logic signed [32:0] o);
    logic signed [33:0] s;
    s = {{2{c[31]}}, c} + {o[32], o};
    if (s > 34'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (s < -34'sh0_8000_0000) begin
      return 32'sh8000_0000;
    end
    return s[31:0];
  endfunction

  // Configuration registers.
  logic signed [31:0] cx_q, cy_q, cz_q;
  logic [30:0]        radius_q;
  logic [6:0]         step_q;
  logic [7:0]         base_r_q, base_g_q, base_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q     <= '0;
      cy_q     <= '0;
      cz_q     <= '0;
      radius_q <= RADIUS_RST;
      step_q   <= 7'(usm_pkg::STEP_RESET);
      base_r_q <= '0;
      base_g_q <= '0;
      base_b_q <= '0;
    end else if (cfg_we_i) begin
      unique case (usm_pkg::cfg_reg_e'(cfg_idx_i))
        usm_pkg::CFG_CENTER_X: cx_q     <= cfg_data_i;
        usm_pkg::CFG_CENTER_Y: cy_q     <= cfg_data_i;
        usm_pkg::CFG_CENTER_Z: cz_q     <= cfg_data_i;
        usm_pkg::CFG_RADIUS:   radius_q <= cfg_data_i[30:0];
        usm_pkg::CFG_STEP:     step_q   <= cfg_data_i[6:0];
        usm_pkg::CFG_RED:      base_r_q <= cfg_data_i[7:0];
        usm_pkg::CFG_GREEN:    base_g_q <= cfg_data_i[7:0];
        usm_pkg::CFG_BLUE:     base_b_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Request and mesh geometry.
  logic              op_q;
  logic [15:0]       idx_q;
  logic [P_W-1:0]    p_q;
  logic [T_W-1:0]    n_q, t_q;
  logic              err_q;
  logic [P_W-1:0]    p_d;
  logic [usm_pkg::R_W-1:0] r_d;
  logic [T_W-1:0]    rp_d;
  logic [T_W-1:0]    idx_x;

  assign idx_x = T_W'(idx_q);
  assign p_d   = usm_pkg::step_points(step_q);
  assign r_d   = usm_pkg::R_W'((p_d >> 1) - 1'b1);
  assign rp_d  = T_W'(r_d) * T_W'(p_d);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      idx_q <= item_index_i & IDX_MASK;
    end
    if (cmd_i.setup) begin
      p_q <= p_d;
      n_q <= rp_d + T_W'(2);
      t_q <= {rp_d[T_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q <= 1'b0;
    end else if (cmd_i.check) begin
      err_q <= (p_q == '0) ||
               ((op_q == usm_pkg::OP_TRIANGLE) ? (idx_x >= t_q) : (idx_x >= n_q));
    end
  end

  // Divider: ring and point of a vertex, or band and point of a triangle.
  logic [usm_pkg::DIV_W-1:0] div_num;
  logic [usm_pkg::DIV_W-1:0] quot;
  logic [P_W-1:0]            rem;
  logic                      div_busy;
  logic [T_W-1:0]            tri_off;

  assign tri_off = idx_x - T_W'(p_q);
  assign div_num = (op_q == usm_pkg::OP_TRIANGLE) ? usm_pkg::DIV_W'(tri_off >> 1)
                                                  : usm_pkg::DIV_W'(idx_x - 1'b1);

  usm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.check),
    .num_i   (div_num),
    .den_i   (p_q),
    .busy_o  (div_busy),
    .quot_o  (quot),
    .rem_o   (rem)
  );

  // Vertex angles and ramp length.
  logic              pole_top, pole_bot, pole_q, pole_neg_q;
  logic [7:0]        ring1;
  logic [15:0]       lat_prod, lon_prod;
  logic [7:0]        lat_mag;
  logic              lat_neg;
  logic [6:0]        alat;
  logic [8:0]        lon, lon_c;
  logic              last_pt;
  logic [8:0]        steps_full;
  logic [3:0]        steps;
  logic [6:0]        ck_q, zk_q;
  logic              zneg_q;
  usm_pkg::trig_ref_t sl_q, cl_q;

  assign pole_top = idx_q == '0;
  assign pole_bot = idx_x == n_q - 1'b1;
  assign ring1    = 8'(quot) + 8'd1;
  assign lat_prod = 16'(step_q) * 16'(ring1);
  assign lon_prod = 16'(step_q) * 16'(rem);
  assign lat_mag  = pole_top ? 8'd0 : (pole_bot ? 8'(usm_pkg::HALF_TURN) : lat_prod[7:0]);
  assign lat_neg  = lat_mag > 8'(usm_pkg::QUARTER);
  assign alat     = lat_neg ? 7'(lat_mag - 8'(usm_pkg::QUARTER))
                            : 7'(8'(usm_pkg::QUARTER) - lat_mag);
  assign lon      = (pole_top || pole_bot) ? 9'd0 : lon_prod[8:0];
  assign lon_c    = (lon <= 9'(usm_pkg::QUARTER)) ? 9'(9'(usm_pkg::QUARTER) - lon)
                    : 9'(10'(usm_pkg::FULL_TURN + usm_pkg::QUARTER) - 10'(lon));
  assign last_pt  = rem == p_q - 1'b1;
  assign steps_full = 9'(quot[7:0]) + 9'(last_pt) + 9'd1;
  assign steps    = pole_bot ? 4'd0 : (pole_top ? 4'd1 :
                    ((steps_full > 9'(usm_pkg::RAMP_LIMIT)) ? 4'(usm_pkg::RAMP_LIMIT)
                                                            : steps_full[3:0]));

  always_ff @(posedge clk_i) begin
    if (cmd_i.post) begin
      pole_q     <= pole_top || pole_bot;
      pole_neg_q <= pole_bot;
      ck_q       <= 7'(7'(usm_pkg::QUARTER) - alat);
      zk_q       <= alat;
      zneg_q     <= lat_neg;
      sl_q       <= usm_pkg::sin_ref(lon);
      cl_q       <= usm_pkg::sin_ref(lon_c);
    end
  end

  // Color ramp, one step per cycle alongside the multiplies.
  logic [3:0] ramp_cnt_q;
  logic [7:0] acc_r_q, acc_g_q, acc_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_cnt_q <= '0;
    end else if (cmd_i.post) begin
      ramp_cnt_q <= steps;
    end else if (ramp_cnt_q != '0) begin
      ramp_cnt_q <= ramp_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.post) begin
      acc_r_q <= base_r_q;
      acc_g_q <= base_g_q;
      acc_b_q <= base_b_q;
    end else if (ramp_cnt_q != '0) begin
      acc_r_q <= ramp_step(acc_r_q);
      acc_g_q <= ramp_step(acc_g_q);
      acc_b_q <= ramp_step(acc_b_q);
    end
  end

  // Shared multiplier: product registered, rounded and written back next cycle.
  logic [30:0]        mul_a, mul_b;
  logic               mul_neg;
  logic [61:0]        prod_q;
  logic               pneg_q;
  usm_pkg::mul_sel_e  wsel_q;
  logic               wv_q;
  logic [61:0]        rnd;
  logic [31:0]        mag;
  logic signed [32:0] off;
  logic [30:0]        rxy_q;
  logic signed [32:0] ox_q, oy_q, oz_q;

  always_comb begin
    unique case (cmd_i.mul_sel)
      usm_pkg::MUL_RXY: begin
        mul_a   = radius_q;
        mul_b   = usm_pkg::SIN_TAB[ck_q];
        mul_neg = 1'b0;
      end
      usm_pkg::MUL_Z: begin
        mul_a   = radius_q;
        mul_b   = usm_pkg::SIN_TAB[zk_q];
        mul_neg = zneg_q;
      end
      usm_pkg::MUL_X: begin
        mul_a   = rxy_q;
        mul_b   = usm_pkg::SIN_TAB[cl_q.k];
        mul_neg = cl_q.neg;
      end
      default: begin
        mul_a   = rxy_q;
        mul_b   = usm_pkg::SIN_TAB[sl_q.k];
        mul_neg = sl_q.neg;
      end
    endcase
  end

  assign rnd = prod_q + (62'd1 << 29);
  assign mag = rnd[61:30];
  assign off = pneg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wv_q <= 1'b0;
    end else begin
      wv_q <= cmd_i.mul_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_issue) begin
      prod_q <= {31'd0, mul_a} * {31'd0, mul_b};
      pneg_q <= mul_neg;
      wsel_q <= cmd_i.mul_sel;
    end
    if (wv_q) begin
      unique case (wsel_q)
        usm_pkg::MUL_RXY: rxy_q <= mag[30:0];
        usm_pkg::MUL_Z: begin
          if (pole_q) begin
            oz_q <= pole_neg_q ? -$signed({2'b00, radius_q}) : $signed({2'b00, radius_q});
          end else begin
            oz_q <= off;
          end
        end
        usm_pkg::MUL_X: ox_q <= off;
        default:        oy_q <= off;
      endcase
    end
  end

  // Triangle corners.
  logic [T_W-1:0] cap_b, cap_c, bot_start, ub, first, bot_b, bot_c;
  logic [T_W-1:0] base, cur, nx, band_b, band_c;
  logic [T_W-1:0] ca_d, cb_d, cc_d;
  logic [15:0]    ca_q, cb_q, cc_q;

  always_comb begin
    cap_b     = idx_x + 1'b1;
    cap_c     = (idx_x == T_W'(p_q) - 1'b1) ? T_W'(1) : idx_x + T_W'(2);
    bot_start = t_q - T_W'(p_q);
    ub        = idx_x - bot_start;
    first     = n_q - T_W'(p_q) - 1'b1;
    bot_b     = first + ub;
    bot_c     = (ub == T_W'(p_q) - 1'b1) ? first : first + ub + 1'b1;
    base      = T_W'(quot[7:0]) * T_W'(p_q) + 1'b1;
    cur       = base + T_W'(rem);
    nx        = base + (last_pt ? T_W'(0) : T_W'(rem) + 1'b1);
    if (!tri_off[0]) begin
      band_b = cur + T_W'(p_q);
      band_c = nx + T_W'(p_q);
    end else begin
      band_b = nx + T_W'(p_q);
      band_c = nx;
    end
    priority if (idx_x < T_W'(p_q)) begin
      ca_d = '0;
      cb_d = cap_b;
      cc_d = cap_c;
    end else if (idx_x >= bot_start) begin
      ca_d = n_q - 1'b1;
      cb_d = bot_b;
      cc_d = bot_c;
    end else begin
      ca_d = cur;
      cb_d = band_b;
      cc_d = band_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tri_calc) begin
      ca_q <= ca_d[15:0];
      cb_q <= cb_d[15:0];
      cc_q <= cc_d[15:0];
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      pos_x_o    <= '0;
      pos_y_o    <= '0;
      pos_z_o    <= '0;
      red_o      <= '0;
      green_o    <= '0;
      blue_o     <= '0;
      corner_a_o <= '0;
      corner_b_o <= '0;
      corner_c_o <= '0;
      status_o   <= err_q;
      if (!err_q) begin
        if (op_q == usm_pkg::OP_TRIANGLE) begin
          corner_a_o <= ca_q;
          corner_b_o <= cb_q;
          corner_c_o <= cc_q;
        end else begin
          pos_x_o <= sat_add(cx_q, ox_q);
          pos_y_o <= sat_add(cy_q, oy_q);
          pos_z_o <= sat_add(cz_q, oz_q);
          red_o   <= acc_r_q;
          green_o <= acc_g_q;
          blue_o  <= acc_b_q;
        end
      end
    end
  end

  assign stat_o.err       = err_q;
  assign stat_o.is_tri    = op_q == usm_pkg::OP_TRIANGLE;
  assign stat_o.div_busy  = div_busy;
  assign stat_o.ramp_busy = ramp_cnt_q != '0;

endmodule

@@ rtl/core/usm_chk.sv @@
module usm_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [31:0] pos_x_i,
  input logic [31:0] pos_y_i,
  input logic [31:0] pos_z_i,
  input logic [7:0]  red_i,
  input logic [7:0]  green_i,
  input logic [7:0]  blue_i,
  input logic [15:0] corner_a_i,
  input logic [15:0] corner_b_i,
  input logic [15:0] corner_c_i,
  input logic        status_i
);

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result item dropped while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(pos_x_i) && $stable(corner_b_i) &&
      $stable(status_i))
    else $error("result item changed while stalled");

  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i |-> pos_x_i == 0 && pos_y_i == 0 && pos_z_i == 0 &&
      red_i == 0 && green_i == 0 && blue_i == 0 && corner_a_i == 0 &&
      corner_b_i == 0 && corner_c_i == 0)
    else $error("error item carries data");

  a_triangle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !status_i && corner_b_i != 0 |-> pos_x_i == 0 && pos_y_i == 0 &&
      pos_z_i == 0 && red_i == 0 && green_i == 0 && blue_i == 0)
    else $error("triangle item carries vertex data");

  a_vertex_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !status_i && corner_b_i == 0 |-> corner_a_i == 0 && corner_c_i == 0)
    else $error("vertex item carries corner data");

endmodule

bind uv_sphere_mesh_generator_top usm_chk u_usm_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp.valid),
  .rsp_ready_i (rsp.ready),
  .pos_x_i     (rsp.pos_x),
  .pos_y_i     (rsp.pos_y),
  .pos_z_i     (rsp.pos_z),
  .red_i       (rsp.red),
  .green_i     (rsp.green),
  .blue_i      (rsp.blue),
  .corner_a_i  (rsp.corner_a),
  .corner_b_i  (rsp.corner_b),
  .corner_c_i  (rsp.corner_c),
  .status_i    (rsp.status)
);
